### sv/assert_macros.svh
// assertion macros for the checker in miq_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define MIQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define MIQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/miq_pkg.sv
// types and constants for the motion input qualifier
// no dependencies
`default_nettype none

package miq_pkg;

  localparam int TIME_W  = 32;
  localparam int DELAY_W = 16;
  localparam int SENS_W  = 2;
  localparam int CIDX_W  = 3;
  localparam int CDAT_W  = 16;

  localparam logic [CIDX_W-1:0] REG_DEBOUNCE_DELAY = 3'd0;
  localparam logic [CIDX_W-1:0] REG_HOLD_DURATION  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_SENSITIVITY    = 3'd2;
  localparam logic [CIDX_W-1:0] REG_ACTIVE_LEVEL   = 3'd3;
  localparam logic [CIDX_W-1:0] REG_DETECTION_MODE = 3'd4;

  localparam logic [SENS_W-1:0] SENS_LOW    = 2'd0;
  localparam logic [SENS_W-1:0] SENS_MEDIUM = 2'd1;
  localparam logic [SENS_W-1:0] SENS_HIGH   = 2'd2;

  localparam logic MODE_HOLD  = 1'b0;
  localparam logic MODE_PULSE = 1'b1;

  localparam logic [TIME_W-1:0] LOCKOUT_LOW    = 32'd3;
  localparam logic [TIME_W-1:0] LOCKOUT_MEDIUM = 32'd1;

  typedef struct packed {
    logic [DELAY_W-1:0] debounce_delay;
    logic [DELAY_W-1:0] hold_duration;
    logic [SENS_W-1:0]  sensitivity;
    logic               active_level;
    logic               detection_mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    debounce_delay: '0,
    hold_duration:  '0,
    sensitivity:    SENS_MEDIUM,
    active_level:   1'b1,
    detection_mode: MODE_HOLD
  };

  typedef struct packed {
    logic              raw_level;
    logic [TIME_W-1:0] now_seconds;
  } smp_t;

  typedef struct packed {
    logic              changed;
    logic              motion;
    logic              active;
    logic              detect_event;
    logic              end_event;
    logic [TIME_W-1:0] last_detection;
    logic [TIME_W-1:0] inactive_time;
  } res_t;

  // handshake state of the sample stage seen by the core
  typedef struct packed {
    logic valid;
    smp_t smp;
  } stage_t;

endpackage

`default_nettype wire

### sv/miq_if.sv
// channel interfaces for samples, results and register writes
// depends on miq_pkg
`default_nettype none

interface miq_in_if;
  import miq_pkg::*;
  logic              valid;
  logic              ready;
  logic              raw_level;
  logic [TIME_W-1:0] now_seconds;
  modport source (output valid, raw_level, now_seconds, input ready);
  modport sink   (input valid, raw_level, now_seconds, output ready);
endinterface

interface miq_out_if;
  import miq_pkg::*;
  logic              valid;
  logic              ready;
  logic              changed;
  logic              motion;
  logic              active;
  logic              detect_event;
  logic              end_event;
  logic [TIME_W-1:0] last_detection;
  logic [TIME_W-1:0] inactive_time;
  modport source (output valid, changed, motion, active, detect_event, end_event,
                  last_detection, inactive_time, input ready);
  modport sink   (input valid, changed, motion, active, detect_event, end_event,
                  last_detection, inactive_time, output ready);
endinterface

interface miq_cfg_if;
  import miq_pkg::*;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CDAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/motion_input_qualifier.sv
// Motion input qualifier: takes one sensor sample (pin level and time in seconds) per beat
// and returns one result per sample. A sample is registered on entry, then logic checks the
// active level, applies the sensitivity lockout, debounces and updates the detector state
// (stable flag and detection time) while the result register loads, so each result passes
// the input register and then the result register; a new sample is taken every cycle while
// the result receiver does not stall. Register writes are registered and must only come
// while no sample is in flight.
// depends on miq_pkg, the channel interfaces, miq_cfg_regs, miq_in_reg and miq_core
`default_nettype none

module motion_input_qualifier (
  input wire logic clk,
  input wire logic rst_n,
  miq_in_if.sink     in_ch,
  miq_out_if.source  out_ch,
  miq_cfg_if.sink    cfg_ch
);
  import miq_pkg::*;

  cfg_t   cfg;
  stage_t stage;
  logic   adv;

  miq_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  miq_in_reg u_in (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .adv   (adv),
    .stage (stage)
  );

  miq_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .stage  (stage),
    .adv    (adv),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

### sv/miq_cfg_regs.sv
// configuration register file, one write beat per cycle
// depends on miq_pkg and miq_cfg_if
`default_nettype none

module miq_cfg_regs (
  input  wire logic    clk,
  input  wire logic    rst_n,
  miq_cfg_if.sink      cfg_ch,
  output miq_pkg::cfg_t cfg
);
  import miq_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_DEBOUNCE_DELAY: cfg_nxt.debounce_delay = cfg_ch.data;
        REG_HOLD_DURATION:  cfg_nxt.hold_duration  = cfg_ch.data;
        REG_SENSITIVITY:    cfg_nxt.sensitivity    = cfg_ch.data[SENS_W-1:0];
        REG_ACTIVE_LEVEL:   cfg_nxt.active_level   = cfg_ch.data[0];
        REG_DETECTION_MODE: cfg_nxt.detection_mode = cfg_ch.data[0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/miq_in_reg.sv
// sample input register with its beat handshake
// depends on miq_pkg and miq_in_if
`default_nettype none

module miq_in_reg (
  input  wire logic       clk,
  input  wire logic       rst_n,
  miq_in_if.sink          in_ch,
  input  wire logic       adv,
  output miq_pkg::stage_t stage
);
  import miq_pkg::*;

  logic valid_r;
  logic valid_nxt;
  smp_t smp_r;
  logic take;

  assign in_ch.ready = !valid_r || adv;
  assign take = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      smp_r <= '{raw_level: in_ch.raw_level, now_seconds: in_ch.now_seconds};
    end
  end

  assign stage = '{valid: valid_r, smp: smp_r};

endmodule

`default_nettype wire

### sv/miq_core.sv
// qualify, lockout, debounce and hold logic with detector state and result register
// depends on miq_pkg and miq_out_if
`default_nettype none

module miq_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire miq_pkg::cfg_t   cfg,
  input  wire miq_pkg::stage_t stage,
  output logic                 adv,
  miq_out_if.source            out_ch
);
  import miq_pkg::*;

  logic              stable_r, stable_nxt;
  logic              prev_r, prev_nxt;
  logic [TIME_W-1:0] dbs_r, dbs_nxt;
  logic [TIME_W-1:0] det_r, det_nxt;
  logic              ovalid_r, ovalid_nxt;
  res_t              res_r, res_nxt;

  logic [TIME_W-1:0] now;
  logic [TIME_W-1:0] since;
  logic [TIME_W-1:0] db_elapsed;
  logic [TIME_W-1:0] hold_elapsed;
  logic              present;
  logic              lock_ok;
  logic              q;
  logic              restart;
  logic              follow;
  logic              step;

  assign adv  = !ovalid_r || out_ch.ready;
  assign step = adv && stage.valid;
  assign now  = stage.smp.now_seconds;

  always_comb begin
    present = (stage.smp.raw_level == cfg.active_level);
    since   = now - det_r;
    case (cfg.sensitivity)
      SENS_LOW:  lock_ok = since > LOCKOUT_LOW;
      SENS_HIGH: lock_ok = 1'b1;
      default:   lock_ok = since > LOCKOUT_MEDIUM;
    endcase
    q       = present && lock_ok;
    restart = (q != prev_r);

    // a level change restarts the window on this sample
    db_elapsed = restart ? '0 : now - dbs_r;
    follow     = (db_elapsed > {{(TIME_W-DELAY_W){1'b0}}, cfg.debounce_delay})
                 && (q != stable_r);

    stable_nxt = follow ? q : stable_r;
    det_nxt    = (follow && q) ? now : det_r;
    dbs_nxt    = restart ? now : dbs_r;
    prev_nxt   = q;

    hold_elapsed = now - det_nxt;

    res_nxt.changed        = follow;
    res_nxt.motion         = stable_nxt && ((cfg.detection_mode == MODE_PULSE) ||
                             (hold_elapsed <= {{(TIME_W-DELAY_W){1'b0}}, cfg.hold_duration}));
    res_nxt.active         = stable_nxt;
    res_nxt.detect_event   = follow && q;
    res_nxt.end_event      = follow && !q;
    res_nxt.last_detection = det_nxt;
    res_nxt.inactive_time  = stable_nxt ? '0 : hold_elapsed;

    ovalid_nxt = adv ? stage.valid : ovalid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= 1'b0;
      prev_r   <= 1'b0;
      dbs_r    <= '0;
      det_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
      if (step) begin
        stable_r <= stable_nxt;
        prev_r   <= prev_nxt;
        dbs_r    <= dbs_nxt;
        det_r    <= det_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = ovalid_r;
  assign out_ch.changed        = res_r.changed;
  assign out_ch.motion         = res_r.motion;
  assign out_ch.active         = res_r.active;
  assign out_ch.detect_event   = res_r.detect_event;
  assign out_ch.end_event      = res_r.end_event;
  assign out_ch.last_detection = res_r.last_detection;
  assign out_ch.inactive_time  = res_r.inactive_time;

endmodule

`default_nettype wire

### sv/miq_checker.sv
// port-level checks on the motion input qualifier, bound to the top level
// depends on miq_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module miq_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic                      changed,
  input wire logic                      active,
  input wire logic                      detect_event,
  input wire logic                      end_event,
  input wire logic [miq_pkg::TIME_W-1:0] inactive_time
);
  import miq_pkg::*;

  // a pending result beat stays until taken
  `MIQ_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result beat dropped")

  `MIQ_ASSERT(a_edge_excl, clk, rst_n, out_valid |-> !(detect_event && end_event), "both edges set")

  `MIQ_ASSERT(a_edge_changed, clk, rst_n, out_valid && (detect_event || end_event) |-> changed && (active == detect_event), "edge pulse without matching flag change")

  `MIQ_ASSERT(a_active_idle, clk, rst_n, out_valid && active |-> inactive_time == '0, "inactive time nonzero while active")

  `MIQ_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind motion_input_qualifier miq_checker u_miq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .changed       (out_ch.changed),
  .active        (out_ch.active),
  .detect_event  (out_ch.detect_event),
  .end_event     (out_ch.end_event),
  .inactive_time (out_ch.inactive_time)
);

`default_nettype wire

### tb/sv/miq_result_checker.sv
// result checker for the motion input qualifier: predicts every result beat from the
// sample and register write beats it sees and compares them in order
// depends on miq_pkg and the channel interfaces in miq_if

module miq_result_checker
  import miq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  miq_in_if         in_ch,
  miq_out_if        out_ch,
  miq_cfg_if        cfg_ch,
  output int        fail_count,
  output int        pending,
  output int        checked,
  output int        rises,
  output int        falls
);

  cfg_t              regs;
  logic              stable_q;
  logic              last_q;
  logic [TIME_W-1:0] db_start;
  logic [TIME_W-1:0] det_time;
  res_t              awaited_reports[$];

  function automatic res_t qualify_sample(smp_t s);
    logic [TIME_W-1:0] since;
    logic [TIME_W-1:0] held;
    logic              present;
    logic              q;
    res_t              r;
    present = (s.raw_level == regs.active_level);
    since = s.now_seconds - det_time;
    case (regs.sensitivity)
      SENS_LOW:  q = present && (since > LOCKOUT_LOW);
      SENS_HIGH: q = present;
      default:   q = present && (since > LOCKOUT_MEDIUM);
    endcase
    r = '0;
    if (q != last_q) db_start = s.now_seconds;
    held = s.now_seconds - db_start;
    if (held > TIME_W'(regs.debounce_delay) && q != stable_q) begin
      stable_q = q;
      r.changed = 1'b1;
      if (q) begin
        det_time = s.now_seconds;
        r.detect_event = 1'b1;
      end else begin
        r.end_event = 1'b1;
      end
    end
    last_q = q;
    since = s.now_seconds - det_time;
    r.active = stable_q;
    r.motion = stable_q &&
               (regs.detection_mode == MODE_PULSE || since <= TIME_W'(regs.hold_duration));
    r.last_detection = det_time;
    r.inactive_time = stable_q ? '0 : since;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    smp_t smp;
    res_t want;
    res_t got;
    if (!rst_n) begin
      regs = CFG_RESET;
      stable_q = 1'b0;
      last_q = 1'b0;
      db_start = '0;
      det_time = '0;
      awaited_reports.delete();
      fail_count = 0;
      checked = 0;
      rises = 0;
      falls = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{changed: out_ch.changed, motion: out_ch.motion, active: out_ch.active,
                detect_event: out_ch.detect_event, end_event: out_ch.end_event,
                last_detection: out_ch.last_detection, inactive_time: out_ch.inactive_time};
        if (awaited_reports.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result beat: chg=%b mot=%b act=%b det=%b end=%b last=%0d inact=%0d",
                   $time, got.changed, got.motion, got.active, got.detect_event,
                   got.end_event, got.last_detection, got.inactive_time);
        end else begin
          want = awaited_reports.pop_front();
          checked++;
          if (got.detect_event) rises++;
          if (got.end_event) falls++;
          if (got !== want) begin
            fail_count++;
            $display("%0t mismatch expected chg=%b mot=%b act=%b det=%b end=%b last=%0d inact=%0d",
                     $time, want.changed, want.motion, want.active, want.detect_event,
                     want.end_event, want.last_detection, want.inactive_time);
            $display("%0t          actual   chg=%b mot=%b act=%b det=%b end=%b last=%0d inact=%0d",
                     $time, got.changed, got.motion, got.active, got.detect_event,
                     got.end_event, got.last_detection, got.inactive_time);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        smp = '{raw_level: in_ch.raw_level, now_seconds: in_ch.now_seconds};
        awaited_reports.push_back(qualify_sample(smp));
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_DEBOUNCE_DELAY: regs.debounce_delay = cfg_ch.data[DELAY_W-1:0];
          REG_HOLD_DURATION:  regs.hold_duration = cfg_ch.data[DELAY_W-1:0];
          REG_SENSITIVITY:    regs.sensitivity = cfg_ch.data[SENS_W-1:0];
          REG_ACTIVE_LEVEL:   regs.active_level = cfg_ch.data[0];
          REG_DETECTION_MODE: regs.detection_mode = cfg_ch.data[0];
          default: ;
        endcase
      end
    end
    pending = awaited_reports.size();
  end

endmodule

### tb/sv/tb.sv
// top of the motion input qualifier testbench: clock, reset, sample and register stimulus,
// receiver stalls and the verdict
// depends on miq_pkg, miq_if, motion_input_qualifier and miq_result_checker

module tb;
  import miq_pkg::*;

  localparam int LIMIT       = 500000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 90;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL        = 20;
  localparam logic [CIDX_W-1:0] REG_COUNT  = 3'd5;
  localparam logic [SENS_W-1:0] SENS_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  miq_in_if  in_ch ();
  miq_out_if out_ch ();
  miq_cfg_if cfg_ch ();

  int fail_count;
  int pending;
  int checked;
  int rises;
  int falls;

  motion_input_qualifier DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  miq_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .rises      (rises),
    .falls      (falls)
  );

  int   cycle_count  = 0;
  int   samples_sent = 0;
  int   reg_writes   = 0;
  int   burst_left   = 0;
  int   hold_asks    = 0;
  bit   gaps_on      = 1'b1;

  initial begin : receiver
    int hold_left;
    int served;
    int epoch_left;
    int stall_pct;
    hold_left = 0;
    served = 0;
    epoch_left = 0;
    stall_pct = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (served != hold_asks) begin
        served = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (epoch_left == 0) begin
          epoch_left = $urandom_range(32, 400);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 60;
            default: stall_pct = 85;
          endcase
        end
        epoch_left--;
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("motion_input_qualifier verification failed");
    $finish;
  end

  function automatic cfg_t make_cfg(logic [DELAY_W-1:0] dd, logic [DELAY_W-1:0] hd,
                                    logic [SENS_W-1:0] sens, logic lvl, logic mode);
    cfg_t c;
    c.debounce_delay = dd;
    c.hold_duration = hd;
    c.sensitivity = sens;
    c.active_level = lvl;
    c.detection_mode = mode;
    return c;
  endfunction

  function automatic logic [DELAY_W-1:0] pick_delay();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return DELAY_W'($urandom_range(0, 4));
    if (r < 8) return DELAY_W'($urandom_range(5, 40));
    if (r == 8) return '1;
    return DELAY_W'($urandom_range(0, 65535));
  endfunction

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    reg_writes++;
  endtask

  task automatic program_regs(cfg_t c, bit stray);
    logic [CDAT_W-1:0] pad;
    write_reg(REG_DEBOUNCE_DELAY, c.debounce_delay);
    write_reg(REG_HOLD_DURATION, c.hold_duration);
    pad = CDAT_W'($urandom);
    write_reg(REG_SENSITIVITY, {pad[CDAT_W-1:SENS_W], c.sensitivity});
    pad = CDAT_W'($urandom);
    write_reg(REG_ACTIVE_LEVEL, {pad[CDAT_W-1:1], c.active_level});
    pad = CDAT_W'($urandom);
    write_reg(REG_DETECTION_MODE, {pad[CDAT_W-1:1], c.detection_mode});
    if (stray) begin
      for (int k = REG_COUNT; k < (1 << CIDX_W); k++) write_reg(CIDX_W'(k), CDAT_W'($urandom));
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic offer_sample(logic lvl, logic [TIME_W-1:0] t);
    in_ch.valid <= 1'b1;
    in_ch.raw_level <= lvl;
    in_ch.now_seconds <= t;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    samples_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        burst_left = $urandom_range(1, 40);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    cfg_t              c;
    logic [TIME_W-1:0] wall;
    logic [TIME_W-1:0] step;
    logic              lvl;
    logic              run_present;
    int                run_left;
    int                r;
    in_ch.valid = 1'b0;
    in_ch.raw_level = 1'b0;
    in_ch.now_seconds = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings, lockout right after reset and the top of the time range
    offer_sample(1'b1, 32'd0);
    offer_sample(1'b1, 32'd2);
    offer_sample(1'b1, 32'd3);
    offer_sample(1'b0, 32'd4);
    offer_sample(1'b1, 32'hFFFF_FFFF);

    wait_results_drained();
    program_regs(make_cfg(16'd1, 16'hFFFF, SENS_LOW, 1'b0, MODE_PULSE), 1'b0);
    offer_sample(1'b0, 32'd10);
    offer_sample(1'b0, 32'd11);
    offer_sample(1'b0, 32'd13);
    offer_sample(1'b1, 32'd14);
    offer_sample(1'b0, 32'd20);

    // spare sensitivity code, ignored register indexes, time wrap
    wait_results_drained();
    program_regs(make_cfg(16'd0, 16'd0, SENS_SPARE, 1'b1, MODE_HOLD), 1'b1);
    offer_sample(1'b1, 32'hFFFF_FFFE);
    offer_sample(1'b1, 32'hFFFF_FFFF);
    offer_sample(1'b0, 32'd0);
    offer_sample(1'b1, 32'd1);
    offer_sample(1'b1, 32'd5);

    wait_results_drained();
    program_regs(make_cfg(16'd0, 16'd2, SENS_HIGH, 1'b1, MODE_HOLD), 1'b0);
    offer_sample(1'b1, 32'd100);
    offer_sample(1'b1, 32'd101);
    offer_sample(1'b1, 32'd102);
    offer_sample(1'b1, 32'd103);
    offer_sample(1'b1, 32'd104);

    // debounce restart and the longest debounce window
    wait_results_drained();
    program_regs(make_cfg(16'hFFFF, 16'd5, SENS_MEDIUM, 1'b1, MODE_HOLD), 1'b0);
    offer_sample(1'b1, 32'd200);
    offer_sample(1'b0, 32'd201);
    offer_sample(1'b1, 32'd202);
    offer_sample(1'b1, 32'd70000);
    offer_sample(1'b1, 32'h8000_0000);

    run_present = 1'b0;
    run_left = 0;
    for (int p = 0; p < PHASES; p++) begin
      wait_results_drained();
      case (p)
        0: c = make_cfg(16'd0, 16'd0, SENS_LOW, 1'b0, MODE_HOLD);
        1: c = make_cfg(16'hFFFF, 16'hFFFF, SENS_SPARE, 1'b1, MODE_PULSE);
        default: c = make_cfg(pick_delay(), pick_delay(), SENS_W'($urandom_range(0, 3)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
      program_regs(c, (p % 4) == 2);
      gaps_on = (p != 3) && (p != 5);
      if (p == 3) hold_asks++;
      wall = ((p % 3) == 1) ? 32'hFFFF_FF00 + TIME_W'($urandom_range(0, 255)) : $urandom;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 7 && i == PHASE_ITEMS / 2) wait_results_drained();
        if (run_left == 0) begin
          run_present = !run_present;
          run_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 10);
        end
        run_left--;
        lvl = run_present ? c.active_level : !c.active_level;
        if ($urandom_range(0, 99) < 12) lvl = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 88) step = TIME_W'($urandom_range(0, 3));
        else if (r < 94) step = TIME_W'($urandom_range(4, 300));
        else if (r < 97) step = TIME_W'($urandom_range(0, 131071));
        else step = $urandom;
        wall = wall + step;
        offer_sample(lvl, wall);
      end
    end

    wait_results_drained();
    repeat (TAIL) @(negedge clk);
    $display("covered %0d samples under %0d register settings using %0d register writes",
             samples_sent, PHASES + 5, reg_writes);
    $display("compared %0d results including %0d rising and %0d falling detections",
             checked, rises, falls);
    if (fail_count == 0 && pending == 0) begin
      $display("motion_input_qualifier verification clean");
    end else begin
      $display("motion_input_qualifier verification failed");
    end
    $finish;
  end

endmodule
